>>> rtl/rmpc_pkg.sv
// Shared types and constants for the rumble motor pulse controller.
`timescale 1ns / 1ps

package rmpc_pkg;

    localparam int PIPE_DEPTH_DEF = 3;

    localparam int CMD_W      = 3;
    localparam int DURATION_W = 15;
    localparam int LEVEL_W    = 8;
    localparam int FRAME_W    = 32;
    localparam int KIND_W     = 2;
    localparam int KICK_W     = 3;
    localparam int SLIP_W     = 3;
    localparam int MOTOR_W    = 2;
    localparam int ACCUM_W    = 16;
    localparam int CALC_W     = 24;
    localparam int CFG_IDX_W  = 2;

    localparam int MUL_STEPS  = LEVEL_W;
    localparam int DIV_STEPS  = FRAME_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int CUBE_SHIFT = 9;

    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_QUEUE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DECAY     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SLIP      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_VIBRATE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SUBMERGED = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CANCEL    = 3'd6;

    localparam logic [MOTOR_W-1:0] MOTOR_NONE  = 2'd0;
    localparam logic [MOTOR_W-1:0] MOTOR_START = 2'd1;
    localparam logic [MOTOR_W-1:0] MOTOR_STOP  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STRONG = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WEAK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STRONG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KICK_FRAMES      = 2'd1;

    localparam logic [LEVEL_W-1:0] STRONG_THRESHOLD_RST = 8'd70;
    localparam logic [KICK_W-1:0]  KICK_FRAMES_RST      = 3'd4;

    localparam logic [ACCUM_W-1:0] PULSE_UNIT = 16'h0100;
    localparam logic [ACCUM_W-1:0] PULSE_BIAS = 16'd4;
    localparam logic [ACCUM_W-1:0] IDLE_MARGIN = 16'd4;

    localparam logic [SLIP_W-1:0] SLIP_ARM       = 3'd7;
    localparam logic [SLIP_W-1:0] SLIP_MIN       = 3'd4;
    localparam logic [SLIP_W-1:0] SLIP_PERIOD    = 3'd7;
    localparam logic [SLIP_W-1:0] SUBMERGED_SLIP = 3'd4;
    localparam logic [SLIP_W-1:0] SUBMERGED_PER  = 3'd4;
    localparam logic [SLIP_W-1:0] VIB_BASE       = 3'd5;
    localparam logic [SLIP_W-1:0] VIB_MAX        = 3'd4;
    localparam logic [SLIP_W-1:0] SLIP_FULL      = 3'd5;
    localparam logic [SLIP_W-1:0] SLIP_VIB       = 3'd2;

    typedef struct packed {
        logic               start;
        logic               is_mod;
        logic [LEVEL_W-1:0] level;
        logic [SLIP_W-1:0]  divisor;
        logic [FRAME_W-1:0] dividend;
    } calc_req_t;

    typedef struct packed {
        logic              done;
        logic [CALC_W-1:0] cube;
        logic              rem_zero;
    } calc_rsp_t;

endpackage

>>> rtl/rmpc_step_unit.sv
// One step of shift-add multiply or restoring divide on a single shared adder.
`timescale 1ns / 1ps

module rmpc_step_unit (
    input  logic                      op_div,
    input  logic [rmpc_pkg::CALC_W-1:0] a,
    input  logic [rmpc_pkg::CALC_W-1:0] b,
    input  logic                      bit_in,
    output logic [rmpc_pkg::CALC_W-1:0] y
);
    import rmpc_pkg::*;

    logic [CALC_W-1:0] shifted;
    logic [CALC_W-1:0] lhs;
    logic [CALC_W-1:0] rhs;
    logic [CALC_W:0]   sum;

    assign shifted = {a[CALC_W-2:0], bit_in};
    assign lhs     = op_div ? shifted : a;
    assign rhs     = op_div ? ~b : (bit_in ? b : '0);
    assign sum     = {1'b0, lhs} + {1'b0, rhs} + {{CALC_W{1'b0}}, op_div};

    always_comb begin
        if (op_div) begin
            y = sum[CALC_W] ? sum[CALC_W-1:0] : shifted;
        end else begin
            y = sum[CALC_W-1:0];
        end
    end

endmodule

>>> rtl/rmpc_calc.sv
// Sequencer for level cube and frame modulo over the shared step unit.
`timescale 1ns / 1ps

module rmpc_calc (
    input  logic                aclk,
    input  logic                aresetn,
    input  rmpc_pkg::calc_req_t req,
    output rmpc_pkg::calc_rsp_t rsp
);
    import rmpc_pkg::*;

    typedef enum logic [3:0] {
        CS_IDLE = 4'b0001,
        CS_SQ   = 4'b0010,
        CS_CU   = 4'b0100,
        CS_DIV  = 4'b1000
    } calc_state_t;

    calc_state_t        state_reg, state_next;
    logic [CALC_W-1:0]  acc_reg, acc_next;
    logic [CALC_W-1:0]  mcand_reg, mcand_next;
    logic [LEVEL_W-1:0] mplier_reg, mplier_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [FRAME_W-1:0] dividend_reg, dividend_next;
    logic [SLIP_W-1:0]  divisor_reg, divisor_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;

    logic               op_div;
    logic [CALC_W-1:0]  step_b;
    logic               step_bit;
    logic [CALC_W-1:0]  step_y;

    assign op_div   = (state_reg == CS_DIV);
    assign step_b   = op_div ? {{(CALC_W-SLIP_W){1'b0}}, divisor_reg} : mcand_reg;
    assign step_bit = op_div ? dividend_reg[FRAME_W-1] : mplier_reg[0];

    rmpc_step_unit u_step (
        .op_div (op_div),
        .a      (acc_reg),
        .b      (step_b),
        .bit_in (step_bit),
        .y      (step_y)
    );

    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        level_next    = level_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                if (req.start) begin
                    acc_next = '0;
                    if (req.is_mod) begin
                        dividend_next = req.dividend;
                        divisor_next  = req.divisor;
                        cnt_next      = CNT_W'(DIV_STEPS - 1);
                        state_next    = CS_DIV;
                    end else begin
                        mcand_next  = CALC_W'(req.level);
                        mplier_next = req.level;
                        level_next  = req.level;
                        cnt_next    = CNT_W'(MUL_STEPS - 1);
                        state_next  = CS_SQ;
                    end
                end
            end
            CS_SQ: begin
                acc_next    = step_y;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    acc_next    = '0;
                    mcand_next  = step_y;
                    mplier_next = level_reg;
                    cnt_next    = CNT_W'(MUL_STEPS - 1);
                    state_next  = CS_CU;
                end
            end
            CS_CU: begin
                acc_next    = step_y;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            CS_DIV: begin
                acc_next      = step_y;
                dividend_next = dividend_reg << 1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        level_reg    <= level_next;
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        cnt_reg      <= cnt_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.cube     = acc_reg;
    assign rsp.rem_zero = (acc_reg == '0);

endmodule

>>> rtl/rumble_motor_pulse_controller.sv
// Top level of the rumble motor pulse controller: handshake, request pipe and drive state.
`timescale 1ns / 1ps

// Takes one event per input beat and returns one result beat per event. Non-tick
// commands skip the drive decision. A tick also waits on the calc unit when a weak
// request needs its next pulse increment (level cubed through two 8-step shift-add
// passes of the shared step unit) or when vibrate mode needs frame_number modulo the
// period (a 32-step restoring divide on the same unit). The input is not ready while
// an event is in work; a finished result waits in the output register and the next
// event may be accepted meanwhile. Configuration writes are always ready.

module rumble_motor_pulse_controller #(
    parameter int PIPE_DEPTH = rmpc_pkg::PIPE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rmpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rmpc_pkg::LEVEL_W-1:0]      cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rmpc_pkg::CMD_W-1:0]        s_command,
    input  logic [rmpc_pkg::DURATION_W-1:0]   s_duration,
    input  logic [rmpc_pkg::LEVEL_W-1:0]      s_strength,
    input  logic [rmpc_pkg::LEVEL_W-1:0]      s_decay_step,
    input  logic [rmpc_pkg::SLIP_W-1:0]       s_vibrate_level,
    input  logic [rmpc_pkg::FRAME_W-1:0]      s_frame_number,
    input  logic                              s_reset_pending,
    input  logic                              s_demo_active,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rmpc_pkg::MOTOR_W-1:0]      m_motor_command,
    output logic                              m_idle
);
    import rmpc_pkg::*;

    localparam int LAST = PIPE_DEPTH - 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DRIVE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;

    logic [KIND_W-1:0]     kind_reg  [PIPE_DEPTH];
    logic [KIND_W-1:0]     kind_next [PIPE_DEPTH];
    logic [DURATION_W-1:0] dur_reg   [PIPE_DEPTH];
    logic [DURATION_W-1:0] dur_next  [PIPE_DEPTH];
    logic [LEVEL_W-1:0]    lvl_reg   [PIPE_DEPTH];
    logic [LEVEL_W-1:0]    lvl_next  [PIPE_DEPTH];
    logic [LEVEL_W-1:0]    dec_reg   [PIPE_DEPTH];
    logic [LEVEL_W-1:0]    dec_next  [PIPE_DEPTH];

    logic [KICK_W-1:0]     kick_reg, kick_next;
    logic [DURATION_W-1:0] frames_reg, frames_next;
    logic [LEVEL_W-1:0]    cur_level_reg, cur_level_next;
    logic [LEVEL_W-1:0]    cur_decay_reg, cur_decay_next;
    logic [KIND_W-1:0]     cur_kind_reg, cur_kind_next;
    logic [ACCUM_W-1:0]    accum_reg, accum_next;
    logic [SLIP_W-1:0]     slip_reg, slip_next;
    logic [SLIP_W-1:0]     period_reg, period_next;

    logic [LEVEL_W-1:0]    threshold_reg, threshold_next;
    logic [KICK_W-1:0]     kick_frames_reg, kick_frames_next;

    logic [FRAME_W-1:0]    frame_reg, frame_next;
    logic                  rst_pend_reg, rst_pend_next;
    logic                  wait_mod_reg, wait_mod_next;
    logic [MOTOR_W-1:0]    motor_reg, motor_next;

    logic                  m_valid_reg, m_valid_next;
    logic [MOTOR_W-1:0]    m_motor_reg, m_motor_next;
    logic                  m_idle_reg, m_idle_next;

    logic                  s_beat;
    logic                  out_free;
    logic [LEVEL_W-1:0]    level_dec;
    logic [SLIP_W-1:0]     slip_armed;
    logic [ACCUM_W-1:0]    drive_sum;
    logic                  pipe_busy;
    logic                  idle_now;

    calc_req_t             calc_req;
    calc_rsp_t             calc_rsp;

    rmpc_calc u_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (calc_req),
        .rsp     (calc_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_beat    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign level_dec  = (cur_level_reg > cur_decay_reg) ? cur_level_reg - cur_decay_reg : '0;
    assign slip_armed = (slip_reg == '0) ? SLIP_ARM : ((slip_reg < SLIP_MIN) ? SLIP_MIN : slip_reg);
    assign drive_sum  = {{(ACCUM_W-KICK_W){1'b0}}, kick_reg}
                      + {{(ACCUM_W-DURATION_W){1'b0}}, frames_reg};

    always_comb begin
        pipe_busy = 1'b0;
        for (int i = 0; i < PIPE_DEPTH; i++) begin
            pipe_busy = pipe_busy || (kind_reg[i] != KIND_NONE);
        end
    end

    assign idle_now = (drive_sum < IDLE_MARGIN) && !pipe_busy;

    always_comb begin
        threshold_next   = threshold_reg;
        kick_frames_next = kick_frames_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_STRONG_THRESHOLD: threshold_next   = cfg_data;
                REG_KICK_FRAMES:      kick_frames_next = cfg_data[KICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        for (int i = 0; i < PIPE_DEPTH; i++) begin
            kind_next[i] = kind_reg[i];
            dur_next[i]  = dur_reg[i];
            lvl_next[i]  = lvl_reg[i];
            dec_next[i]  = dec_reg[i];
        end
        kick_next      = kick_reg;
        frames_next    = frames_reg;
        cur_level_next = cur_level_reg;
        cur_decay_next = cur_decay_reg;
        cur_kind_next  = cur_kind_reg;
        accum_next     = accum_reg;
        slip_next      = slip_reg;
        period_next    = period_reg;
        frame_next     = frame_reg;
        rst_pend_next  = rst_pend_reg;
        wait_mod_next  = wait_mod_reg;
        motor_next     = motor_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_motor_next   = m_motor_reg;
        m_idle_next    = m_idle_reg;

        calc_req.start    = 1'b0;
        calc_req.is_mod   = 1'b0;
        calc_req.level    = level_dec;
        calc_req.divisor  = period_reg;
        calc_req.dividend = frame_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    motor_next = MOTOR_NONE;
                    state_next = S_DONE;
                    case (s_command)
                        CMD_TICK: begin
                            if (kind_reg[0] != KIND_NONE) begin
                                accum_next     = '0;
                                kick_next      = kick_frames_reg;
                                cur_kind_next  = kind_reg[0];
                                frames_next    = dur_reg[0];
                                cur_level_next = lvl_reg[0];
                                cur_decay_next = dec_reg[0];
                            end
                            for (int i = 0; i < PIPE_DEPTH - 1; i++) begin
                                kind_next[i] = kind_reg[i+1];
                                dur_next[i]  = dur_reg[i+1];
                                lvl_next[i]  = lvl_reg[i+1];
                                dec_next[i]  = dec_reg[i+1];
                            end
                            kind_next[LAST] = KIND_NONE;
                            frame_next      = s_frame_number;
                            rst_pend_next   = s_reset_pending;
                            state_next      = S_DRIVE;
                        end
                        CMD_QUEUE: begin
                            if (!s_demo_active) begin
                                kind_next[LAST] = (s_strength > threshold_reg) ?
                                                  KIND_STRONG : KIND_WEAK;
                                lvl_next[LAST]  = s_strength;
                                dur_next[LAST]  = s_duration;
                                dec_next[LAST]  = '0;
                            end
                        end
                        CMD_DECAY: begin
                            dec_next[LAST] = s_decay_step;
                        end
                        CMD_SLIP: begin
                            if (!s_demo_active) begin
                                slip_next   = slip_armed;
                                period_next = SLIP_PERIOD;
                            end
                        end
                        CMD_VIBRATE: begin
                            if (!s_demo_active) begin
                                slip_next = slip_armed;
                                if (s_vibrate_level <= VIB_MAX) begin
                                    period_next = VIB_BASE - s_vibrate_level;
                                end
                            end
                        end
                        CMD_SUBMERGED: begin
                            if (!s_demo_active) begin
                                slip_next   = SUBMERGED_SLIP;
                                period_next = SUBMERGED_PER;
                            end
                        end
                        CMD_CANCEL: begin
                            for (int i = 0; i < PIPE_DEPTH; i++) begin
                                kind_next[i] = KIND_NONE;
                            end
                            frames_next = '0;
                            slip_next   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRIVE: begin
                state_next = S_DONE;
                if (rst_pend_reg) begin
                    motor_next = MOTOR_STOP;
                end else begin
                    if (slip_reg != '0) begin
                        slip_next = slip_reg - 1'b1;
                    end
                    if (kick_reg != '0) begin
                        kick_next  = kick_reg - 1'b1;
                        motor_next = MOTOR_START;
                    end else if (frames_reg != '0) begin
                        frames_next    = frames_reg - 1'b1;
                        cur_level_next = level_dec;
                        if (cur_kind_reg == KIND_STRONG) begin
                            motor_next = MOTOR_START;
                        end else if (accum_reg >= PULSE_UNIT) begin
                            accum_next = accum_reg - PULSE_UNIT;
                            motor_next = MOTOR_START;
                        end else begin
                            calc_req.start = 1'b1;
                            wait_mod_next  = 1'b0;
                            motor_next     = MOTOR_STOP;
                            state_next     = S_WAIT;
                        end
                    end else if (slip_reg >= SLIP_FULL) begin
                        motor_next = MOTOR_START;
                    end else if (slip_reg >= SLIP_VIB && period_reg != '0) begin
                        calc_req.start  = 1'b1;
                        calc_req.is_mod = 1'b1;
                        wait_mod_next   = 1'b1;
                        state_next      = S_WAIT;
                    end else begin
                        motor_next = MOTOR_STOP;
                    end
                end
            end
            S_WAIT: begin
                if (calc_rsp.done) begin
                    if (wait_mod_reg) begin
                        motor_next = calc_rsp.rem_zero ? MOTOR_START : MOTOR_STOP;
                    end else begin
                        accum_next = accum_reg
                                   + ACCUM_W'(calc_rsp.cube[CALC_W-1:CUBE_SHIFT])
                                   + PULSE_BIAS;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_motor_next = motor_reg;
                    m_idle_next  = idle_now;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                kind_reg[i] <= KIND_NONE;
            end
            kick_reg        <= '0;
            frames_reg      <= '0;
            cur_level_reg   <= '0;
            cur_decay_reg   <= '0;
            cur_kind_reg    <= KIND_NONE;
            accum_reg       <= '0;
            slip_reg        <= '0;
            period_reg      <= '0;
            threshold_reg   <= STRONG_THRESHOLD_RST;
            kick_frames_reg <= KICK_FRAMES_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                kind_reg[i] <= kind_next[i];
            end
            kick_reg        <= kick_next;
            frames_reg      <= frames_next;
            cur_level_reg   <= cur_level_next;
            cur_decay_reg   <= cur_decay_next;
            cur_kind_reg    <= cur_kind_next;
            accum_reg       <= accum_next;
            slip_reg        <= slip_next;
            period_reg      <= period_next;
            threshold_reg   <= threshold_next;
            kick_frames_reg <= kick_frames_next;
            m_valid_reg     <= m_valid_next;
        end
        for (int i = 0; i < PIPE_DEPTH; i++) begin
            dur_reg[i] <= dur_next[i];
            lvl_reg[i] <= lvl_next[i];
            dec_reg[i] <= dec_next[i];
        end
        frame_reg    <= frame_next;
        rst_pend_reg <= rst_pend_next;
        wait_mod_reg <= wait_mod_next;
        motor_reg    <= motor_next;
        m_motor_reg  <= m_motor_next;
        m_idle_reg   <= m_idle_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_motor_command = m_motor_reg;
    assign m_idle          = m_idle_reg;

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        calc_rsp.done |-> state_reg == S_WAIT)
        else $error("calc unit finished outside the wait state");

    a_tick_drives: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && s_command == CMD_TICK |=> state_reg == S_DRIVE)
        else $error("accepted tick did not enter drive decision");

    a_accum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        accum_reg[ACCUM_W-1] == 1'b0)
        else $error("pulse accumulator out of range");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && !out_free |=> state_reg == S_DONE)
        else $error("result dropped while output busy");

endmodule
